@@ design/gfe_pkg.sv @@
// shared types, constants and coefficient table of the gamma function evaluator
`default_nettype none
package gfe_pkg;

  localparam int NumCoeffsDef = 27;
  localparam int InFracDef    = 24;
  localparam int OutFracDef   = 32;
  localparam int ZW           = 30;
  localparam int GW           = 64;
  localparam int SumFrac      = 60;
  localparam int MaxCoeffs    = 32;
  localparam int CoefIdxW     = 5;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_SAT   = 2'd1,
    ST_POLE  = 2'd2
  } status_e;

  typedef logic [MaxCoeffs-1:0][63:0] coef_tab_t;

  typedef struct packed {
    logic                load;
    logic                up_load;
    logic                dn_load;
    logic                pole;
    logic                mul_step;
    logic [1:0]          pidx;
    logic                norm;
    logic                x_dec;
    logic                ser_init;
    logic                ser_load;
    logic                ser_acc;
    logic [CoefIdxW-1:0] coef_idx;
    logic                fin_start;
    logic                div_step;
    logic                sh_setup;
    logic                shift_step;
    logic                finish;
  } gfe_cmd_t;

  typedef struct packed {
    logic x_gt_one;
    logic x_neg;
    logic t_zero;
    logic div;
    logic sc_zero;
  } gfe_sts_t;

  // decimal fraction digits to an unsigned value with 60 fraction bits, truncated
  function automatic logic [63:0] frac_digits_q60(input string d);
    logic [63:0] r;
    logic [63:0] dig;
    logic [7:0]  ch;
    int          i;
    r = '0;
    for (i = d.len() - 1; i >= 0; i--) begin
      ch  = d[i];
      dig = 64'((ch - 8'd48) & 8'd15);
      if (dig > 64'd9) dig = 64'd9;
      r = ((dig << SumFrac) + r) / 64'd10;
    end
    return r;
  endfunction

  function automatic logic [63:0] coef_value(input int n);
    logic [63:0] mag;
    mag = '0;
    case (n)
      0: mag = 64'd1 << SumFrac;
      1: mag = frac_digits_q60(
        "5772156649015328574847107526236417396399473414593683294694448354");
      2: mag = frac_digits_q60(
        "9890559953279716055879006187112349085181194245439605371493621847");
      3: mag = frac_digits_q60(
        "9074790760807840913849637364128458684942765833469234123768037827");
      4: mag = frac_digits_q60(
        "9817280868287493872829494368343906581423463320746975472327806233");
      5: mag = frac_digits_q60(
        "9819950687133308024036797799970825430041145353647966988985601196");
      6: mag = frac_digits_q60(
        "9931491103560720422277583602583809840640935608838069770575025500");
      7: mag = frac_digits_q60(
        "9960016921875578703578265696608380067250364412371040786498723143");
      8: mag = frac_digits_q60(
        "9981048811182184740194832873848235437462323425587398485676418276");
      9: mag = frac_digits_q60(
        "9990178339256502246393676805933536852541867471072467946582140434");
      10: mag = frac_digits_q60(
        "9994621279751838577149190275163130262747245024804575366693054501");
      11: mag = frac_digits_q60(
        "9994473777770612291622853078667857569155792808053497759251338579");
      12: mag = frac_digits_q60(
        "9984234865818553609719362575102820190846558249735448507547378456");
      13: mag = frac_digits_q60(
        "9942964224792548885499600606423283534205252993190213223445278409");
      14: mag = frac_digits_q60(
        "9817415529373300718490015920863342801408285485623247052344540861");
      15: mag = frac_digits_q60(
        "9505087356260045072671857543877141073379640221543396483474575002");
      16: mag = frac_digits_q60(
        "8862340777038458017327321534931532223720878671817192171976377175");
      17: mag = frac_digits_q60(
        "7766020439022703527799336629113315125364278308070082251553428261");
      18: mag = frac_digits_q60(
        "6218261781120564563123419874557456000659195749648797901211510819");
      19: mag = frac_digits_q60(
        "4417060348412027926063218282522105999297358388447257554947061329");
      20: mag = frac_digits_q60(
        "2701475353497292098269379690209491963786354304362498578566182867");
      21: mag = frac_digits_q60(
        "1378768248000485686016129493050214125669796790493931341733992288");
      22: mag = frac_digits_q60(
        "05666741300908340721257290134619610032425452294036514887478396272");
      23: mag = frac_digits_q60(
        "01791721124454662588127948572017495010218971969715187449742012969");
      24: mag = frac_digits_q60(
        "004073484259812306386189879368456543383087672500179665265686023159");
      25: mag = frac_digits_q60(
        "0005909388467936236862167480758102751061875702154896091292021547692");
      26: mag = frac_digits_q60(
        "00004099576613045368062084546287872853816528530699297713842313");
      default: mag = '0;
    endcase
    return (n % 2 == 1) ? (64'd0 - mag) : mag;
  endfunction

  function automatic coef_tab_t build_coef_tab();
    coef_tab_t tab;
    int        n;
    for (n = 0; n < MaxCoeffs; n++) begin
      tab[n] = coef_value(n);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

@@ design/gamma_function_evaluator.sv @@
// top level of the gamma function evaluator: Gamma(1+z) from a fixed-point z
// sequence: upward or downward reduction steps (up to 32 steps), then the series terms
//   (NUM_COEFFS-1 terms), then the final multiply or the final division, then the
//   output shift; all multiplies use the one shared 32x32 multiplier (4 partial
//   products a multiply), the division uses the bit-serial divider
// throughput: one transaction at a time; the next is taken while a result waits
// reset: rst_ni asynchronous active low clears the controller and output valid
`default_nettype none
module gamma_function_evaluator import gfe_pkg::*; #(
  parameter int NUM_COEFFS    = NumCoeffsDef,
  parameter int IN_FRAC_BITS  = InFracDef,
  parameter int OUT_FRAC_BITS = OutFracDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // input transaction
  input  wire logic          z_valid_i,
  output logic               z_stall_o,
  input  wire logic [ZW-1:0] z_value_i,
  // result transaction
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [GW-1:0]      gamma_value_o,
  output logic [1:0]         status_o
);

  gfe_cmd_t     cmd;
  gfe_sts_t     sts;
  logic         out_load;
  logic         out_busy;
  logic [GW-1:0] gamma_res;
  status_e      status_res;

  logic          out_valid_q, out_valid_d;
  logic [GW-1:0] gamma_q;
  status_e       status_q;

  // output register is busy while holding a result not yet taken
  assign out_busy = out_valid_q && out_stall_i;

  gfe_ctrl #(
    .NUM_COEFFS (NUM_COEFFS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (z_valid_i),
    .out_busy_i (out_busy),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (z_stall_o),
    .out_load_o (out_load)
  );

  gfe_datapath #(
    .IN_FRAC_BITS  (IN_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .z_value_i (z_value_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .gamma_o   (gamma_res),
    .status_o  (status_res)
  );

  // valid drops when the result is taken, rises when a new one is loaded
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load)                    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      gamma_q  <= gamma_res;
      status_q <= status_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign gamma_value_o = gamma_q;
  assign status_o      = status_q;

  // a pole always reports a zero value
  a_pole_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_POLE) |-> (gamma_value_o == '0))
    else $error("pole result with nonzero value");

  // saturation reports one of the two extreme values
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_SAT) |->
      (gamma_value_o == {1'b1, 63'd0} || gamma_value_o == {1'b0, {63{1'b1}}}))
    else $error("saturated result not at full scale");

  // an accepted transaction makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (z_valid_i && !z_stall_o) |=> z_stall_o)
    else $error("input not stalled after accept");

endmodule
`default_nettype wire

@@ design/gfe_datapath.sv @@
// datapath: reduction factor, shared 32x32 multiplier, series, divider and rounding
`default_nettype none
module gfe_datapath import gfe_pkg::*; #(
  parameter int IN_FRAC_BITS  = InFracDef,
  parameter int OUT_FRAC_BITS = OutFracDef
) (
  input  wire logic            clk_i,
  input  wire logic [ZW-1:0]   z_value_i,
  input  wire gfe_cmd_t        cmd_i,
  output gfe_sts_t             sts_o,
  output logic [GW-1:0]        gamma_o,
  output status_e              status_o
);

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_RIGHT  = 2'd1,
    MODE_LEFT   = 2'd2
  } shmode_e;

  localparam logic signed [31:0] One = 32'sd1 <<< IN_FRAC_BITS;
  localparam coef_tab_t CoefTab = build_coef_tab();
  localparam logic [63:0] ClampPos = 64'd1 << 62;
  localparam logic signed [64:0] Clamp65 = 65'sd1 <<< 62;
  localparam logic signed [16:0] MulShOff = 17'(OUT_FRAC_BITS - SumFrac);
  localparam logic signed [16:0] DivShOff = 17'(OUT_FRAC_BITS - SumFrac - 64);

  logic signed [31:0] x_q, x_d;
  logic [63:0]        m_q, m_d;
  logic signed [15:0] e_q, e_d;
  logic               neg_q, neg_d, div_q, div_d, pole_q, pole_d;
  logic [63:0]        a_q, a_d, b_q, b_d;
  logic [127:0]       acc_q, acc_d;
  logic signed [63:0] s_q, s_d;
  logic               sneg_q, sneg_d;
  shmode_e            mode_q, mode_d;
  logic [7:0]         sc_q, sc_d;
  logic               ovf_q, ovf_d;
  logic [63:0]        mag_q, mag_d;

  logic signed [31:0] t;
  logic [31:0]        t_abs;
  logic [31:0]        a_part, b_part;
  logic [63:0]        pp;
  logic [127:0]       pp_sh;
  logic [5:0]         nlen;
  logic [127:0]       acc_shr;
  logic [127:0]       rsum;
  logic [63:0]        rclamp;
  logic signed [64:0] term, sum65;
  logic [63:0]        coef;
  logic [63:0]        s_abs;
  logic [63:0]        div_r, div_r2;
  logic               div_take;
  logic signed [16:0] sh;
  logic [16:0]        nsh;
  logic [7:0]         rcap;
  logic [127:0]       rres;

  assign t     = x_q + One;
  assign t_abs = t[31] ? 32'(-t) : 32'(t);
  assign s_abs = s_q[63] ? 64'(-s_q) : 64'(s_q);
  assign coef  = CoefTab[cmd_i.coef_idx];

  // one 32x32 partial product per cycle
  always_comb begin
    a_part = cmd_i.pidx[0] ? a_q[63:32] : a_q[31:0];
    b_part = cmd_i.pidx[1] ? b_q[63:32] : b_q[31:0];
    pp     = 64'(a_part) * 64'(b_part);
    case ({1'b0, cmd_i.pidx[0]} + {1'b0, cmd_i.pidx[1]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  // bit length of the product's bits 95:64 for the factor mantissa
  always_comb begin
    nlen = '0;
    for (int i = 0; i < 32; i++) begin
      if (acc_q[64 + i]) nlen = 6'(i + 1);
    end
    acc_shr = acc_q >> nlen;
  end

  // horner step: round the product, clamp, add the coefficient
  always_comb begin
    rsum   = (acc_q >> IN_FRAC_BITS) + 128'(acc_q[IN_FRAC_BITS-1]);
    rclamp = (rsum > 128'(ClampPos)) ? ClampPos : rsum[63:0];
    term   = sneg_q ? -$signed({1'b0, rclamp}) : $signed({1'b0, rclamp});
    sum65  = $signed({coef[63], coef}) + term;
  end

  // restoring division step
  always_comb begin
    div_r    = acc_q[63:0];
    div_r2   = {div_r[62:0], 1'b0};
    div_take = div_r[63] || (div_r2 >= m_q);
  end

  // output exponent shift
  always_comb begin
    if (div_q) sh = DivShOff - 17'(e_q);
    else       sh = 17'(e_q) + MulShOff;
    nsh  = 17'(-sh);
    rcap = (nsh > 17'd130) ? 8'd130 : nsh[7:0];
  end

  assign rres = {1'b0, acc_q[127:1]} + 128'(acc_q[0]);

  always_comb begin
    x_d = x_q; m_d = m_q; e_d = e_q; neg_d = neg_q; div_d = div_q; pole_d = pole_q;
    a_d = a_q; b_d = b_q; acc_d = acc_q; s_d = s_q; sneg_d = sneg_q;
    mode_d = mode_q; sc_d = sc_q; ovf_d = ovf_q; mag_d = mag_q;

    if (cmd_i.load) begin
      x_d    = 32'($signed(z_value_i));
      m_d    = 64'd1 << 63;
      e_d    = -16'sd63;
      neg_d  = 1'b0;
      div_d  = 1'b0;
      pole_d = 1'b0;
    end
    if (cmd_i.up_load) begin
      a_d   = m_q;
      b_d   = 64'(x_q);
      acc_d = '0;
    end
    if (cmd_i.dn_load) begin
      a_d   = m_q;
      b_d   = 64'(t_abs);
      acc_d = '0;
      div_d = 1'b1;
      x_d   = t;
      if (t[31]) neg_d = ~neg_q;
    end
    if (cmd_i.pole) pole_d = 1'b1;
    if (cmd_i.mul_step) acc_d = acc_q + pp_sh;
    if (cmd_i.norm) begin
      m_d = acc_shr[63:0];
      e_d = e_q + 16'(nlen) - 16'(IN_FRAC_BITS);
      if (cmd_i.x_dec) x_d = x_q - One;
    end
    if (cmd_i.ser_init) s_d = $signed(coef);
    if (cmd_i.ser_load) begin
      a_d    = s_abs;
      b_d    = 64'(x_q);
      sneg_d = s_q[63];
      acc_d  = '0;
    end
    if (cmd_i.ser_acc) begin
      if (sum65 > Clamp65)       s_d = 64'(Clamp65);
      else if (sum65 < -Clamp65) s_d = 64'(-Clamp65);
      else                       s_d = 64'(sum65);
    end
    if (cmd_i.fin_start) begin
      neg_d = neg_q ^ s_q[63];
      if (div_q) acc_d = {64'd0, s_abs};
      else begin
        a_d   = s_abs;
        b_d   = m_q;
        acc_d = '0;
      end
    end
    if (cmd_i.div_step) begin
      acc_d[63:0]   = div_take ? (div_r2 - m_q) : div_r2;
      acc_d[127:64] = {acc_q[126:64], div_take};
    end
    if (cmd_i.sh_setup) begin
      ovf_d = 1'b0;
      if (div_q) acc_d = {64'd0, acc_q[127:64]};
      if (!sh[16]) begin
        if (div_q) begin
          mode_d = MODE_LEFT;
          sc_d   = (sh > 17'sd64) ? 8'd64 : sh[7:0];
        end else begin
          mode_d = MODE_DIRECT;
          sc_d   = '0;
          ovf_d  = |acc_q;
        end
      end else begin
        mode_d = MODE_RIGHT;
        sc_d   = rcap - 8'd1;
      end
    end
    if (cmd_i.shift_step) begin
      case (mode_q)
        MODE_RIGHT: begin
          if (sc_q >= 8'd16) begin
            acc_d = acc_q >> 16;
            sc_d  = sc_q - 8'd16;
          end else begin
            acc_d = acc_q >> 1;
            sc_d  = sc_q - 8'd1;
          end
        end
        MODE_LEFT: begin
          ovf_d       = ovf_q | acc_q[63];
          acc_d[63:0] = {acc_q[62:0], 1'b0};
          sc_d        = sc_q - 8'd1;
        end
        default: sc_d = '0;
      endcase
    end
    if (cmd_i.finish) begin
      case (mode_q)
        MODE_RIGHT: begin
          ovf_d = |rres[127:63];
          mag_d = rres[63:0];
        end
        MODE_LEFT: begin
          ovf_d = ovf_q | acc_q[63];
          mag_d = acc_q[63:0];
        end
        default: mag_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; m_q <= m_d; e_q <= e_d; neg_q <= neg_d; div_q <= div_d; pole_q <= pole_d;
    a_q <= a_d; b_q <= b_d; acc_q <= acc_d; s_q <= s_d; sneg_q <= sneg_d;
    mode_q <= mode_d; sc_q <= sc_d; ovf_q <= ovf_d; mag_q <= mag_d;
  end

  assign sts_o.x_gt_one = (x_q > One);
  assign sts_o.x_neg    = x_q[31];
  assign sts_o.t_zero   = (t == 32'sd0);
  assign sts_o.div      = div_q;
  assign sts_o.sc_zero  = (sc_q == 8'd0);

  always_comb begin
    if (pole_q) begin
      gamma_o  = '0;
      status_o = ST_POLE;
    end else if (ovf_q) begin
      gamma_o  = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      status_o = ST_SAT;
    end else begin
      gamma_o  = neg_q ? 64'(-mag_q) : mag_q;
      status_o = ST_VALID;
    end
  end

endmodule
`default_nettype wire

@@ design/gfe_ctrl.sv @@
// controller state machine sequencing reduction, series, final scaling and output
`default_nettype none
module gfe_ctrl import gfe_pkg::*; #(
  parameter int NUM_COEFFS = NumCoeffsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     out_busy_i,
  input  wire gfe_sts_t sts_i,
  output gfe_cmd_t      cmd_o,
  output logic          in_stall_o,
  output logic          out_load_o
);

  localparam int CW = $clog2(NUM_COEFFS);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_UP_CHK   = 13'b0000000000010,
    S_DN_CHK   = 13'b0000000000100,
    S_MUL      = 13'b0000000001000,
    S_NORM     = 13'b0000000010000,
    S_SER_INIT = 13'b0000000100000,
    S_SER_LD   = 13'b0000001000000,
    S_SER_ACC  = 13'b0000010000000,
    S_FIN      = 13'b0000100000000,
    S_DIV      = 13'b0001000000000,
    S_SH_SET   = 13'b0010000000000,
    S_SHIFT    = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_e;

  typedef enum logic [1:0] {
    RET_UP  = 2'd0,
    RET_DN  = 2'd1,
    RET_SER = 2'd2,
    RET_FIN = 2'd3
  } ret_e;

  state_e        state_q, state_d;
  ret_e          ret_q, ret_d;
  logic [1:0]    pidx_q, pidx_d;
  logic [CW-1:0] n_q, n_d;
  logic [5:0]    dcnt_q, dcnt_d;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    pidx_d     = pidx_q;
    n_d        = n_q;
    dcnt_d     = dcnt_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    in_stall_o = (state_q != S_IDLE);
    cmd_o.coef_idx = CoefIdxW'(n_q);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (sts_i.x_gt_one) begin
          cmd_o.up_load = 1'b1;
          ret_d   = RET_UP;
          pidx_d  = '0;
          state_d = S_MUL;
        end else begin
          state_d = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (sts_i.x_neg) begin
          if (sts_i.t_zero) begin
            cmd_o.pole = 1'b1;
            state_d    = S_OUT;
          end else begin
            cmd_o.dn_load = 1'b1;
            ret_d   = RET_DN;
            pidx_d  = '0;
            state_d = S_MUL;
          end
        end else begin
          state_d = S_SER_INIT;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.pidx     = pidx_q;
        pidx_d         = pidx_q + 2'd1;
        if (pidx_q == 2'd3) begin
          case (ret_q)
            RET_UP, RET_DN: state_d = S_NORM;
            RET_SER:        state_d = S_SER_ACC;
            default:        state_d = S_SH_SET;
          endcase
        end
      end
      S_NORM: begin
        cmd_o.norm  = 1'b1;
        cmd_o.x_dec = (ret_q == RET_UP);
        state_d     = S_UP_CHK;
      end
      S_SER_INIT: begin
        cmd_o.ser_init = 1'b1;
        cmd_o.coef_idx = CoefIdxW'(NUM_COEFFS - 1);
        n_d            = CW'(NUM_COEFFS - 2);
        state_d        = S_SER_LD;
      end
      S_SER_LD: begin
        cmd_o.ser_load = 1'b1;
        ret_d   = RET_SER;
        pidx_d  = '0;
        state_d = S_MUL;
      end
      S_SER_ACC: begin
        cmd_o.ser_acc = 1'b1;
        if (n_q == '0) begin
          state_d = S_FIN;
        end else begin
          n_d     = n_q - 1'b1;
          state_d = S_SER_LD;
        end
      end
      S_FIN: begin
        cmd_o.fin_start = 1'b1;
        if (sts_i.div) begin
          dcnt_d  = '0;
          state_d = S_DIV;
        end else begin
          ret_d   = RET_FIN;
          pidx_d  = '0;
          state_d = S_MUL;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) state_d = S_SH_SET;
      end
      S_SH_SET: begin
        cmd_o.sh_setup = 1'b1;
        state_d        = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts_i.sc_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_UP;
      pidx_q  <= '0;
      n_q     <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pidx_q  <= pidx_d;
      n_q     <= n_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule
`default_nettype wire
